[src/pid_position_controller_core_macros.svh]
// Assertion macros shared by the controller RTL.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef PID_POSITION_CONTROLLER_CORE_MACROS_SVH
`define PID_POSITION_CONTROLLER_CORE_MACROS_SVH

`define PPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define PPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ppc_pkg.sv]
`timescale 1ns / 1ps

package ppc_pkg;

  localparam int unsigned GAIN_W = 31;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned X_W    = 34;
  localparam int unsigned XL_W   = 17;
  localparam int unsigned XH_W   = X_W - XL_W;
  localparam int unsigned PL_W   = GAIN_W + XL_W;
  localparam int unsigned PH_W   = GAIN_W + 1 + XH_W;
  localparam int unsigned FULL_W = PH_W + XL_W;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned TERM_W = FULL_W - FRAC_W;
  localparam int unsigned INTEG_W = TERM_W + 1;
  localparam int unsigned SUM_W  = INTEG_W + 1;

  typedef logic [GAIN_W-1:0]        gain_t;
  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [X_W-1:0]    xval_t;
  typedef logic [PL_W-1:0]          plo_t;
  typedef logic signed [PH_W-1:0]   phi_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [INTEG_W-1:0] integ_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef enum logic [2:0] {
    REG_KP,
    REG_KI_HALF_T,
    REG_KD_OVER_T,
    REG_INT_MIN,
    REG_INT_MAX,
    REG_OUT_MIN,
    REG_OUT_MAX
  } cfg_reg_t;

  localparam gain_t KP_RST        = 31'd57016320;
  localparam gain_t KI_HALF_T_RST = 31'd655;
  localparam gain_t KD_OVER_T_RST = 31'd16384000;
  localparam pos_t  INT_MIN_RST   = -32'sd6553600;
  localparam pos_t  INT_MAX_RST   = 32'sd6553600;
  localparam pos_t  OUT_MIN_RST   = -32'sd5701632;
  localparam pos_t  OUT_MAX_RST   = 32'sd5701632;

  // Rebuilds the exact gain product from its two partial products and drops
  // the fraction bits, which rounds toward minus infinity.
  function automatic term_t gain_combine(phi_t ph, plo_t pl);
    logic signed [FULL_W-1:0] full;
    full = $signed({ph, {XL_W{1'b0}}}) + $signed({{(FULL_W-PL_W){1'b0}}, pl});
    return full[FULL_W-1:FRAC_W];
  endfunction

endpackage

[src/pid_position_controller_core.sv]
`timescale 1ns / 1ps

// PID position controller core. Every transfer on the input channel brings a
// setpoint and a measurement in signed Q16.16 and yields exactly one drive value
// with a clamp flag, in order. One item can be accepted in every clock cycle
// while in_stall is low; each result passes through the input, partial product,
// term, integrator and output registers. The gain multiplies are split into
// 31x17 partial products and rebuilt over two stages; the integrator closes its
// loop at the integrator stage. Each stage holds its item while the next is full
// and cannot advance, so a stall on the output only stops the input once every
// stage is occupied. Configuration registers are written through the cfg port;
// the user must write them only while the block is idle; it is not enforced.
module pid_position_controller_core import ppc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [31:0] in_setpoint,
  input  logic signed [31:0] in_measurement,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [31:0] out_drive,
  output logic              out_output_clamped,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  gain_t kp_r, ki_r, kd_r;
  pos_t  int_min_r, int_max_r, out_min_r, out_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r      <= KP_RST;
      ki_r      <= KI_HALF_T_RST;
      kd_r      <= KD_OVER_T_RST;
      int_min_r <= INT_MIN_RST;
      int_max_r <= INT_MAX_RST;
      out_min_r <= OUT_MIN_RST;
      out_max_r <= OUT_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KP:        kp_r      <= cfg_data[GAIN_W-1:0];
        REG_KI_HALF_T: ki_r      <= cfg_data[GAIN_W-1:0];
        REG_KD_OVER_T: kd_r      <= cfg_data[GAIN_W-1:0];
        REG_INT_MIN:   int_min_r <= $signed(cfg_data);
        REG_INT_MAX:   int_max_r <= $signed(cfg_data);
        REG_OUT_MIN:   out_min_r <= $signed(cfg_data);
        REG_OUT_MAX:   out_max_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic in_xfer;

  assign rdy5 = !out_valid_r || !out_stall;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_stall = !rdy1;
  assign in_xfer = in_valid && rdy1;

  // Input stage: error, error sum for the trapezoid, and measurement change.
  logic signed [32:0] err_w, last_err_r;
  pos_t  last_meas_r;
  xval_t xp_r, xi_r, xd_r;
  xval_t xi_nxt, xd_nxt;

  assign err_w  = 33'(in_setpoint) - 33'(in_measurement);
  assign xi_nxt = X_W'(err_w) + X_W'(last_err_r);
  assign xd_nxt = X_W'(in_measurement) - X_W'(last_meas_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      last_err_r  <= '0;
      last_meas_r <= '0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (in_xfer) begin
        last_err_r  <= err_w;
        last_meas_r <= in_measurement;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      xp_r <= X_W'(err_w);
      xi_r <= xi_nxt;
      xd_r <= xd_nxt;
    end
  end

  // Partial products: gain times the low and the high part of each operand.
  plo_t p_lo_r, i_lo_r, d_lo_r;
  phi_t p_hi_r, i_hi_r, d_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      p_lo_r <= PL_W'(kp_r) * PL_W'(xp_r[XL_W-1:0]);
      i_lo_r <= PL_W'(ki_r) * PL_W'(xi_r[XL_W-1:0]);
      d_lo_r <= PL_W'(kd_r) * PL_W'(xd_r[XL_W-1:0]);
      p_hi_r <= PH_W'($signed({1'b0, kp_r})) * PH_W'($signed(xp_r[X_W-1:XL_W]));
      i_hi_r <= PH_W'($signed({1'b0, ki_r})) * PH_W'($signed(xi_r[X_W-1:XL_W]));
      d_hi_r <= PH_W'($signed({1'b0, kd_r})) * PH_W'($signed(xd_r[X_W-1:XL_W]));
    end
  end

  // Term stage: exact products shifted down to Q16.16.
  term_t p_term_r, i_term_r, d_term_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      p_term_r <= gain_combine(p_hi_r, p_lo_r);
      i_term_r <= gain_combine(i_hi_r, i_lo_r);
      d_term_r <= gain_combine(d_hi_r, d_lo_r);
    end
  end

  // Integrator stage. The upper limit is tested first.
  pos_t   integral_r, integral_nxt;
  integ_t integ_w;
  integ_t pd_r;

  assign integ_w = INTEG_W'(integral_r) + INTEG_W'(i_term_r);

  always_comb begin
    if (integ_w > INTEG_W'(int_max_r)) begin
      integral_nxt = int_max_r;
    end else if (integ_w < INTEG_W'(int_min_r)) begin
      integral_nxt = int_min_r;
    end else begin
      integral_nxt = integ_w[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r       <= 1'b0;
      integral_r <= '0;
    end else if (rdy4) begin
      v4_r <= v3_r;
      if (v3_r) begin
        integral_r <= integral_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      pd_r <= INTEG_W'(p_term_r) - INTEG_W'(d_term_r);
    end
  end

  // Output stage: total, output clamp and flag.
  sum_t sum_w;
  pos_t drive_nxt;
  logic clamped_nxt;
  pos_t out_drive_r;
  logic out_clamped_r;

  assign sum_w = SUM_W'(pd_r) + SUM_W'(integral_r);

  always_comb begin
    clamped_nxt = 1'b1;
    if (sum_w > SUM_W'(out_max_r)) begin
      drive_nxt = out_max_r;
    end else if (sum_w < SUM_W'(out_min_r)) begin
      drive_nxt = out_min_r;
    end else begin
      drive_nxt   = sum_w[POS_W-1:0];
      clamped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy5) begin
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && v4_r) begin
      out_drive_r   <= drive_nxt;
      out_clamped_r <= clamped_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_drive          = out_drive_r;
  assign out_output_clamped = out_clamped_r;

`include "pid_position_controller_core_macros.svh"

  `PPC_ASSERT_NEXT(a_int_in_range, rdy4 && v3_r && (int_min_r <= int_max_r), (integral_r <= $past(int_max_r)) && (integral_r >= $past(int_min_r)), "integrator left its limits")
  `PPC_ASSERT_NEXT(a_s1_holds, v1_r && !rdy2, v1_r, "input stage dropped an item")
  `PPC_ASSERT_NOW(a_empty_ready, !v1_r && !v2_r && !v3_r && !v4_r && !out_valid_r, !in_stall, "empty pipeline stalls input")

endmodule

[test/tb_pid_position_controller_core.sv]
`timescale 1ns / 1ps

module tb_pid_position_controller_core;
  import ppc_pkg::*;

  typedef logic signed [79:0] wide_t;

  typedef struct packed {
    pos_t drive;
    logic clamped;
  } drive_result_t;

  localparam logic [2:0] REG_UNUSED_IDX = 3'd7;
  localparam pos_t POS_MAX = 32'sh7FFF_FFFF;
  localparam pos_t POS_MIN = 32'sh8000_0000;
  localparam int STALL_OPEN = 0;
  localparam int STALL_LIGHT = 1;
  localparam int STALL_HEAVY = 2;
  localparam int STALL_TOGGLE = 3;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int MAX_LOGGED = 40;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 190;

  class drive_scoreboard;
    gain_t kp_gain;
    gain_t ki_gain;
    gain_t kd_gain;
    wide_t integ_lo;
    wide_t integ_hi;
    wide_t drive_lo;
    wide_t drive_hi;
    wide_t integ_acc;
    wide_t prev_err;
    wide_t prev_meas;
    drive_result_t expected_q[$];
    int mismatches;
    int checked;

    function new();
      kp_gain = KP_RST;
      ki_gain = KI_HALF_T_RST;
      kd_gain = KD_OVER_T_RST;
      integ_lo = INT_MIN_RST;
      integ_hi = INT_MAX_RST;
      drive_lo = OUT_MIN_RST;
      drive_hi = OUT_MAX_RST;
      integ_acc = '0;
      prev_err = '0;
      prev_meas = '0;
      mismatches = 0;
      checked = 0;
    endfunction

    // Exact Q16.16 gain product; the arithmetic shift floors toward minus infinity.
    function wide_t scaled(gain_t g, wide_t x);
      wide_t gw;
      wide_t prod;
      gw = {49'd0, g};
      prod = gw * x;
      return prod >>> 16;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      pos_t sdata;
      sdata = data;
      case (idx)
        REG_KP: kp_gain = data[30:0];
        REG_KI_HALF_T: ki_gain = data[30:0];
        REG_KD_OVER_T: kd_gain = data[30:0];
        REG_INT_MIN: integ_lo = sdata;
        REG_INT_MAX: integ_hi = sdata;
        REG_OUT_MIN: drive_lo = sdata;
        REG_OUT_MAX: drive_hi = sdata;
        default: ;
      endcase
    endfunction

    function void note_input(pos_t sp, pos_t meas);
      wide_t sp_w;
      wide_t meas_w;
      wide_t err;
      wide_t err_pair;
      wide_t meas_delta;
      wide_t integ;
      wide_t total;
      drive_result_t r;
      sp_w = sp;
      meas_w = meas;
      err = sp_w - meas_w;
      err_pair = err + prev_err;
      meas_delta = meas_w - prev_meas;
      integ = integ_acc + scaled(ki_gain, err_pair);
      if (integ > integ_hi) begin
        integ = integ_hi;
      end else if (integ < integ_lo) begin
        integ = integ_lo;
      end
      integ_acc = integ;
      total = scaled(kp_gain, err) + integ - scaled(kd_gain, meas_delta);
      r.clamped = 1'b0;
      if (total > drive_hi) begin
        total = drive_hi;
        r.clamped = 1'b1;
      end else if (total < drive_lo) begin
        total = drive_lo;
        r.clamped = 1'b1;
      end
      r.drive = total[31:0];
      prev_err = err;
      prev_meas = meas_w;
      expected_q.insert(expected_q.size(), r);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_LOGGED) begin
        $display("MISMATCH at %0t ns: %s", $time, what);
      end
    endtask

    task check_result(pos_t drv, logic clp);
      drive_result_t exp_r;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result drive=%0d", drv));
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (drv !== exp_r.drive) begin
        report_mismatch($sformatf("result %0d drive %0d, want %0d", checked, drv,
                                  exp_r.drive));
      end
      if (clp !== exp_r.clamped) begin
        report_mismatch($sformatf("result %0d clamp flag %b, want %b", checked, clp,
                                  exp_r.clamped));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  pos_t in_setpoint = '0;
  pos_t in_measurement = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pos_t out_drive;
  logic out_output_clamped;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  int hold_requests = 0;
  int holds_done = 0;
  int items_sent = 0;
  int settings_used = 0;
  drive_scoreboard sb;

  pid_position_controller_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_setpoint(in_setpoint),
    .in_measurement(in_measurement),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_drive(out_drive),
    .out_output_clamped(out_output_clamped),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      sb.check_result(out_drive, out_output_clamped);
    end
  end

  // The receiver switches between stall patterns; a requested hold keeps it
  // stalled long enough for the pipeline to fill and stall the input.
  initial begin
    int mode;
    int span;
    int period;
    forever begin
      mode = $urandom_range(STALL_OPEN, STALL_TOGGLE);
      span = $urandom_range(4, 60);
      period = $urandom_range(1, 4);
      for (int k = 0; k < span; k++) begin
        @(posedge clk);
        if (holds_done != hold_requests) begin
          out_stall <= 1'b1;
          repeat (LONG_HOLD_CYCLES) @(posedge clk);
          holds_done++;
          out_stall <= 1'b0;
        end else begin
          case (mode)
            STALL_OPEN: out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 25);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
            default: out_stall <= (((k / period) % 2) == 1);
          endcase
        end
      end
    end
  end

  task automatic send_item(pos_t sp, pos_t meas);
    in_valid <= 1'b1;
    in_setpoint <= sp;
    in_measurement <= meas;
    do @(posedge clk); while (in_stall);
    sb.note_input(sp, meas);
    items_sent++;
  endtask

  task automatic pause_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic apply_setting(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                               logic [31:0] imin, logic [31:0] imax,
                               logic [31:0] omin, logic [31:0] omax);
    write_reg(REG_KP, kp);
    write_reg(REG_KI_HALF_T, ki);
    write_reg(REG_KD_OVER_T, kd);
    write_reg(REG_INT_MIN, imin);
    write_reg(REG_INT_MAX, imax);
    write_reg(REG_OUT_MIN, omin);
    write_reg(REG_OUT_MAX, omax);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  function automatic pos_t rand_pos();
    pos_t v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0: v = POS_MAX;
          1: v = POS_MIN;
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end
      default: begin
        v = $urandom_range(0, 32'h0003_FFFF);
        v = v - 32'sh0002_0000;
      end
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return $urandom;
      2: return $urandom_range(0, 32'h0100_0000);
      default: return $urandom_range(0, 32'h0004_0000);
    endcase
  endfunction

  function automatic pos_t rand_bound(bit upper);
    pos_t v;
    case ($urandom_range(0, 7))
      0: v = $urandom;
      1: v = upper ? POS_MAX : POS_MIN;
      default: begin
        v = $urandom_range(0, 32'h0010_0000);
        if (!upper) begin
          v = -v;
        end
      end
    endcase
    return v;
  endfunction

  // Mostly a tracking loop: the measurement closes in on a setpoint that moves
  // now and then, with unrelated samples mixed in.
  task automatic random_phase(int count, bit with_hold);
    pos_t target;
    pos_t pos;
    pos_t step;
    int burst;
    int sent;
    target = rand_pos();
    pos = rand_pos();
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      if (with_hold && sent == 0) begin
        hold_requests++;
        burst = 48;
      end
      for (int k = 0; k < burst && sent < count; k++) begin
        if ($urandom_range(0, 9) < 7) begin
          if ($urandom_range(0, 19) == 0) begin
            target = rand_pos();
          end
          step = $urandom_range(0, 2047);
          pos = pos + (target - pos) / 8 + step - 1024;
          send_item(target, pos);
        end else begin
          send_item(rand_pos(), rand_pos());
        end
        sent++;
      end
      if ($urandom_range(0, 3) == 0) begin
        pause_sender($urandom_range(1, 8));
      end
    end
    wait_results_drained();
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset gains. The first sample sees zero history.
    send_item(32'sd65536, 32'sd131072);
    send_item(32'sd0, 32'sd0);
    send_item(POS_MAX, POS_MIN);
    send_item(POS_MIN, POS_MAX);
    send_item(POS_MIN, POS_MIN);
    send_item(POS_MAX, POS_MAX);
    send_item(32'sd100, 32'sd40);
    send_item(-32'sd1, 32'sd0);
    wait_results_drained();

    // Full-scale gains written with the top bit set, widest limits.
    apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, POS_MIN, POS_MAX,
                  POS_MIN, POS_MAX);
    send_item(POS_MAX, POS_MIN);
    send_item(POS_MAX, POS_MIN);
    send_item(POS_MIN, POS_MAX);
    send_item(POS_MIN, POS_MAX);
    send_item(32'sd0, 32'sd0);
    send_item(32'sd1, 32'sd0);
    wait_results_drained();

    // Crossed integrator and output limits; a write to the unused index is dropped.
    apply_setting(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'sd655360, -32'sd655360,
                  32'sd327680, -32'sd327680);
    write_reg(REG_UNUSED_IDX, 32'hFFFF_FFFF);
    cfg_we <= 1'b0;
    @(posedge clk);
    send_item(32'sd0, 32'sd0);
    send_item(32'sd655360, 32'sd0);
    send_item(-32'sd655360, 32'sd0);
    send_item(POS_MAX, POS_MIN);
    send_item(32'sd0, POS_MAX);
    wait_results_drained();

    apply_setting(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_item(POS_MAX, POS_MIN);
    send_item(POS_MIN, POS_MAX);
    send_item(32'sd12345, -32'sd54321);
    wait_results_drained();

    apply_setting(32'(KP_RST), 32'(KI_HALF_T_RST), 32'(KD_OVER_T_RST), INT_MIN_RST,
                  INT_MAX_RST, OUT_MIN_RST, OUT_MAX_RST);
    random_phase(PHASE_ITEMS, 1'b0);
    for (int ph = 1; ph < RANDOM_PHASES; ph++) begin
      apply_setting(rand_gain(), rand_gain(), rand_gain(), rand_bound(1'b0),
                    rand_bound(1'b1), rand_bound(1'b0), rand_bound(1'b1));
      random_phase(PHASE_ITEMS, ph == 2);
    end

    repeat (20) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));
    end
    $display("Sent %0d transfers under %0d register settings and compared %0d results.",
             items_sent, settings_used, sb.checked);
    $display("Stimulus covered full-scale gains, crossed limits and a long output hold.");
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out waiting for the block.");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
